// File: rtl/sorted_set_golomb_base62_decoder_unit_assert.svh
// assertion macros for the set decoder
`ifndef SORTED_SET_GOLOMB_BASE62_DECODER_UNIT_ASSERT_SVH
`define SORTED_SET_GOLOMB_BASE62_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define SSGBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssgbd_pkg.sv
package ssgbd_pkg;

    typedef enum logic [2:0] {
        PH_WIDTH  = 3'd0,
        PH_M      = 3'd1,
        PH_FIRST  = 3'd2,
        PH_QUOT   = 3'd3,
        PH_REM    = 3'd4,
        PH_SKIP   = 3'd5,
        PH_BUDGET = 3'd6
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_WIDTH  = 4'd1,
        ST_BAD_M      = 4'd2,
        ST_M_WIDTH    = 4'd3,
        ST_EMPTY      = 4'd4,
        ST_BAD_CHAR   = 4'd5,
        ST_BUDGET     = 4'd6,
        ST_WRAP       = 4'd7,
        ST_RANGE      = 4'd8,
        ST_INCOMPLETE = 4'd9
    } t_status;

    localparam logic [7:0] C_CH_0       = 8'h30;
    localparam logic [7:0] C_CH_9       = 8'h39;
    localparam logic [7:0] C_CH_UA      = 8'h41;
    localparam logic [7:0] C_CH_UZ      = 8'h5a;
    localparam logic [7:0] C_CH_LA      = 8'h61;
    localparam logic [7:0] C_CH_LZ      = 8'h7a;
    // 'a' - 7, 'A' - 5, 'A' - 10, 'a' - 36
    localparam logic [7:0] C_WIDTH_OFS  = 8'd90;
    localparam logic [7:0] C_M_OFS      = 8'd60;
    localparam logic [7:0] C_UPPER_OFS  = 8'd55;
    localparam logic [7:0] C_LOWER_OFS  = 8'd61;
    localparam int         C_QUOT_W     = 28;
    localparam int         C_BUDGET_W   = 27;
    localparam logic [C_QUOT_W-1:0] C_TERM_MAX_ZEROS = 28'd5;

endpackage

// File: rtl/sorted_set_golomb_base62_decoder_unit.sv
// channel  | beat handshake               | payload
// ---------+------------------------------+-------------------------------------------
// in       | i_in_valid / o_in_stall      | i_char_code
// out      | o_out_valid / i_out_stall    | o_value, o_value_valid, o_done_res, o_status
//
// one character per cycle sustained while the result register is not stalled; an input
// beat passes the input register, then the result register; the decode state loop is registered
// a character that yields no result produces no output beat
// i_rst_n is synchronous, active low, and returns the decoder to the width character
// a stalled full result register holds a valid character stage and raises o_in_stall
`include "sorted_set_golomb_base62_decoder_unit_assert.svh"

module sorted_set_golomb_base62_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_value_valid,
    output logic        o_done_res,
    output logic [3:0]  o_status
);

    localparam int QW = ssgbd_pkg::C_QUOT_W;
    localparam int BW = ssgbd_pkg::C_BUDGET_W;

    function automatic logic [QW-1:0] f_qsat(input logic [QW-1:0] a, input logic [2:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {{(QW-2){1'b0}}, b};
        return s[QW] ? {QW{1'b1}} : s[QW-1:0];
    endfunction

    // input stage
    logic        r_in_vld;
    logic [7:0]  r_char;

    // decode state
    ssgbd_pkg::t_phase r_phase, n_phase;
    logic [5:0]    r_width, n_width;
    logic [4:0]    r_m, n_m;
    logic [QW-1:0] r_qc, n_qc;
    logic [BW-1:0] r_budget, n_budget;
    logic [31:0]   r_racc, n_racc;
    logic [4:0]    r_fill, n_fill;
    logic [31:0]   r_prev, n_prev;
    logic          r_first, n_first;

    // result register
    logic                r_out_vld;
    logic [31:0]         r_value;
    logic                r_value_valid;
    logic                r_done;
    ssgbd_pkg::t_status  r_status;

    logic                res_vld;
    logic [31:0]         res_value;
    logic                res_vv;
    logic                res_done;
    ssgbd_pkg::t_status  res_status;

    logic adv;
    logic fire;
    logic is_zero;

    assign adv        = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;
    assign is_zero    = (r_char == 8'd0);

    // character decode
    logic [7:0] w_tmp, m_tmp, d_tmp;
    logic       dig_ok;
    logic [5:0] dig;
    logic       short_dig;
    logic       w_ok, m_ok;
    logic [5:0] m_ext, wm_diff;
    logic [QW-1:0] budget_full;

    assign w_tmp = r_char - ssgbd_pkg::C_WIDTH_OFS;
    assign m_tmp = r_char - ssgbd_pkg::C_M_OFS;
    assign w_ok  = (r_char >= ssgbd_pkg::C_CH_LA) && (r_char <= ssgbd_pkg::C_CH_LZ);
    assign m_ok  = (r_char >= ssgbd_pkg::C_CH_UA) && (r_char <= ssgbd_pkg::C_CH_UZ);
    assign m_ext   = {1'b0, m_tmp[4:0]};
    assign wm_diff = r_width - m_ext;
    assign budget_full = ({{(QW-1){1'b0}}, 1'b1} << wm_diff) - {{(QW-1){1'b0}}, 1'b1};

    always_comb begin
        dig_ok = 1'b1;
        d_tmp  = 8'd0;
        if ((r_char >= ssgbd_pkg::C_CH_0) && (r_char <= ssgbd_pkg::C_CH_9)) begin
            d_tmp = r_char - ssgbd_pkg::C_CH_0;
        end else if (m_ok) begin
            d_tmp = r_char - ssgbd_pkg::C_UPPER_OFS;
        end else if (w_ok) begin
            d_tmp = r_char - ssgbd_pkg::C_LOWER_OFS;
        end else begin
            dig_ok = 1'b0;
        end
    end

    assign dig       = d_tmp[5:0];
    // 'U' and 'V' carry five bits
    assign short_dig = (dig[5:1] == 5'b01111);

    // bit walk over one character
    logic          l_rem;
    logic [4:0]    l_fill;
    logic [31:0]   l_racc;
    logic [2:0]    l_zc;
    logic          l_fresh;
    logic          e_q, e_q_fresh;
    logic [2:0]    e_q_zc;
    logic          e_v, e_v_first;
    logic [31:0]   e_v_racc;

    always_comb begin
        l_rem     = (r_phase == ssgbd_pkg::PH_REM);
        l_fill    = r_fill;
        l_racc    = r_racc;
        l_zc      = 3'd0;
        l_fresh   = 1'b0;
        e_q       = 1'b0;
        e_q_zc    = 3'd0;
        e_q_fresh = 1'b0;
        e_v       = 1'b0;
        e_v_first = 1'b0;
        e_v_racc  = 32'd0;
        for (int i = 0; i < 6; i++) begin
            if (i < 5 || !short_dig) begin
                if (!l_rem) begin
                    if (!dig[i]) begin
                        l_zc = l_zc + 3'd1;
                    end else begin
                        e_q       = 1'b1;
                        e_q_zc    = l_zc;
                        e_q_fresh = l_fresh;
                        l_rem     = 1'b1;
                        l_fill    = 5'd0;
                        l_racc    = 32'd0;
                    end
                end else begin
                    l_racc = l_racc | ({31'd0, dig[i]} << l_fill);
                    if ((l_fill + 5'd1) == r_m) begin
                        e_v       = 1'b1;
                        e_v_first = !e_q;
                        e_v_racc  = l_racc;
                        l_rem     = 1'b0;
                        l_fresh   = 1'b1;
                        l_zc      = 3'd0;
                        l_fill    = 5'd0;
                        l_racc    = 32'd0;
                    end else begin
                        l_fill = l_fill + 5'd1;
                    end
                end
            end
        end
    end

    // quotient, budget and value arithmetic
    logic [QW-1:0] q_end, q_val, q_tail;
    logic          q_fail;
    logic [BW-1:0] budget_left;
    logic [31:0]   delta, base;
    logic [32:0]   next_sum, vmax;
    logic          err_wrap, err_range;

    assign q_end       = e_q_fresh ? {{(QW-3){1'b0}}, e_q_zc} : f_qsat(r_qc, e_q_zc);
    assign q_fail      = q_end > {1'b0, r_budget};
    assign budget_left = r_budget - q_end[BW-1:0];
    assign q_tail      = l_fresh ? {{(QW-3){1'b0}}, l_zc} : f_qsat(r_qc, l_zc);
    assign q_val       = e_v_first ? r_qc : q_end;
    assign delta       = ({{(32-QW){1'b0}}, q_val} << r_m) | e_v_racc;
    assign base        = r_prev + 32'd1;
    assign next_sum    = {1'b0, base} + {1'b0, delta};
    assign vmax        = (33'd1 << r_width) - 33'd1;
    assign err_wrap    = (!r_first && (base == 32'd0)) || next_sum[32];
    assign err_range   = next_sum > vmax;

    always_comb begin
        n_phase    = r_phase;
        n_width    = r_width;
        n_m        = r_m;
        n_qc       = r_qc;
        n_budget   = r_budget;
        n_racc     = r_racc;
        n_fill     = r_fill;
        n_prev     = r_prev;
        n_first    = r_first;
        res_vld    = 1'b0;
        res_value  = 32'd0;
        res_vv     = 1'b0;
        res_done   = 1'b0;
        res_status = ssgbd_pkg::ST_OK;
        case (r_phase)
            ssgbd_pkg::PH_WIDTH: begin
                if (!w_ok) begin
                    res_vld    = 1'b1;
                    res_done   = 1'b1;
                    res_status = ssgbd_pkg::ST_BAD_WIDTH;
                    n_phase    = is_zero ? ssgbd_pkg::PH_WIDTH : ssgbd_pkg::PH_SKIP;
                end else begin
                    n_width = w_tmp[5:0];
                    n_phase = ssgbd_pkg::PH_M;
                end
            end
            ssgbd_pkg::PH_M: begin
                if (!m_ok) begin
                    res_vld    = 1'b1;
                    res_done   = 1'b1;
                    res_status = ssgbd_pkg::ST_BAD_M;
                    n_phase    = is_zero ? ssgbd_pkg::PH_WIDTH : ssgbd_pkg::PH_SKIP;
                end else begin
                    n_m = m_tmp[4:0];
                    if (m_ext >= r_width) begin
                        res_vld    = 1'b1;
                        res_done   = 1'b1;
                        res_status = ssgbd_pkg::ST_M_WIDTH;
                        n_phase    = ssgbd_pkg::PH_SKIP;
                    end else begin
                        n_qc     = '0;
                        n_budget = budget_full[BW-1:0];
                        n_racc   = 32'd0;
                        n_fill   = 5'd0;
                        n_prev   = 32'hFFFF_FFFF;
                        n_first  = 1'b1;
                        n_phase  = ssgbd_pkg::PH_FIRST;
                    end
                end
            end
            ssgbd_pkg::PH_SKIP: begin
                if (is_zero) begin
                    n_phase = ssgbd_pkg::PH_WIDTH;
                end
            end
            ssgbd_pkg::PH_BUDGET: begin
                res_vld    = 1'b1;
                res_done   = 1'b1;
                res_status = ssgbd_pkg::ST_BUDGET;
                n_phase    = is_zero ? ssgbd_pkg::PH_WIDTH : ssgbd_pkg::PH_SKIP;
            end
            ssgbd_pkg::PH_FIRST, ssgbd_pkg::PH_QUOT, ssgbd_pkg::PH_REM: begin
                if (is_zero) begin
                    res_vld  = 1'b1;
                    res_done = 1'b1;
                    n_phase  = ssgbd_pkg::PH_WIDTH;
                    if (r_phase == ssgbd_pkg::PH_FIRST) begin
                        res_status = ssgbd_pkg::ST_EMPTY;
                    end else if ((r_phase == ssgbd_pkg::PH_REM) ||
                                 (r_qc > ssgbd_pkg::C_TERM_MAX_ZEROS)) begin
                        res_status = ssgbd_pkg::ST_INCOMPLETE;
                    end
                end else if (!dig_ok) begin
                    res_vld    = 1'b1;
                    res_done   = 1'b1;
                    res_status = ssgbd_pkg::ST_BAD_CHAR;
                    n_phase    = ssgbd_pkg::PH_SKIP;
                end else if (e_v && e_v_first) begin
                    // value completes before any quotient end
                    if (err_wrap || err_range) begin
                        res_vld    = 1'b1;
                        res_done   = 1'b1;
                        res_status = err_wrap ? ssgbd_pkg::ST_WRAP : ssgbd_pkg::ST_RANGE;
                        n_phase    = ssgbd_pkg::PH_SKIP;
                    end else begin
                        res_vld   = 1'b1;
                        res_vv    = 1'b1;
                        res_value = next_sum[31:0];
                        n_prev    = next_sum[31:0];
                        n_first   = 1'b0;
                        n_racc    = l_racc;
                        n_fill    = l_fill;
                        if (e_q && q_fail) begin
                            n_phase = ssgbd_pkg::PH_BUDGET;
                        end else if (e_q) begin
                            n_budget = budget_left;
                            n_qc     = q_end;
                            n_phase  = ssgbd_pkg::PH_REM;
                        end else begin
                            n_qc    = q_tail;
                            n_phase = ssgbd_pkg::PH_QUOT;
                        end
                    end
                end else if (e_q) begin
                    if (q_fail) begin
                        res_vld    = 1'b1;
                        res_done   = 1'b1;
                        res_status = ssgbd_pkg::ST_BUDGET;
                        n_phase    = ssgbd_pkg::PH_SKIP;
                    end else if (e_v && (err_wrap || err_range)) begin
                        res_vld    = 1'b1;
                        res_done   = 1'b1;
                        res_status = err_wrap ? ssgbd_pkg::ST_WRAP : ssgbd_pkg::ST_RANGE;
                        n_phase    = ssgbd_pkg::PH_SKIP;
                    end else if (e_v) begin
                        res_vld   = 1'b1;
                        res_vv    = 1'b1;
                        res_value = next_sum[31:0];
                        n_prev    = next_sum[31:0];
                        n_first   = 1'b0;
                        n_budget  = budget_left;
                        n_qc      = q_tail;
                        n_racc    = l_racc;
                        n_fill    = l_fill;
                        n_phase   = ssgbd_pkg::PH_QUOT;
                    end else begin
                        n_budget = budget_left;
                        n_qc     = q_end;
                        n_racc   = l_racc;
                        n_fill   = l_fill;
                        n_phase  = ssgbd_pkg::PH_REM;
                    end
                end else begin
                    n_racc  = l_racc;
                    n_fill  = l_fill;
                    if (l_rem) begin
                        n_phase = ssgbd_pkg::PH_REM;
                    end else begin
                        n_qc    = q_tail;
                        n_phase = ssgbd_pkg::PH_QUOT;
                    end
                end
            end
            default: begin
                n_phase = ssgbd_pkg::PH_WIDTH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ssgbd_pkg::PH_WIDTH;
            r_width  <= 6'd0;
            r_m      <= 5'd0;
            r_qc     <= '0;
            r_budget <= '0;
            r_racc   <= 32'd0;
            r_fill   <= 5'd0;
            r_prev   <= 32'hFFFF_FFFF;
            r_first  <= 1'b1;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_m      <= n_m;
            r_qc     <= n_qc;
            r_budget <= n_budget;
            r_racc   <= n_racc;
            r_fill   <= n_fill;
            r_prev   <= n_prev;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld && res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_value       <= res_value;
            r_value_valid <= res_vv;
            r_done        <= res_done;
            r_status      <= res_status;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_value       = r_value;
    assign o_value_valid = r_value_valid;
    assign o_done_res    = r_done;
    assign o_status      = r_status;

    `SSGBD_ASSERT_NOW(a_value_beat_ok, o_out_valid && o_value_valid, !o_done_res && (o_status == ssgbd_pkg::ST_OK), "value beat carries a stop")
    `SSGBD_ASSERT_NEXT(a_budget_after_value, fire && (n_phase == ssgbd_pkg::PH_BUDGET), o_out_valid && o_value_valid, "deferred budget stop without value beat")
    `SSGBD_ASSERT_NEXT(a_budget_no_grow, fire && (r_phase != ssgbd_pkg::PH_M), r_budget <= $past(r_budget), "quotient budget grew outside header")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int ITEM_TARGET    = 1800;

    typedef struct packed {
        logic [31:0] value;
        logic        value_valid;
        logic        done_res;
        logic [3:0]  status;
    } t_decoded;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_char_code   = 8'h00;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_value;
    logic        o_value_valid;
    logic        o_done_res;
    logic [3:0]  o_status;

    // decoder state mirrored by the predictor
    ssgbd_pkg::t_phase dec_phase;
    logic [5:0]  dec_width;
    logic [4:0]  dec_m;
    logic [31:0] quot_count;
    logic [31:0] quot_budget;
    logic [31:0] rem_acc;
    logic [4:0]  rem_fill;
    logic [31:0] prev_value;
    logic        first_pending;

    t_decoded    decoded_q[$];
    t_decoded    want;
    int          chars_sent    = 0;
    int          strings_sent  = 0;
    int          beats_checked = 0;
    int          mismatches    = 0;
    int          idle_cycles   = 0;
    int          stall_left    = 0;
    bit          tx_idle       = 1'b1;
    bit          rx_idle       = 1'b1;
    bit          hold_request  = 1'b0;
    bit          in_beat;
    bit          out_beat;

    sorted_set_golomb_base62_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_value_valid (o_value_valid),
        .o_done_res    (o_done_res),
        .o_status      (o_status)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return ssgbd_pkg::C_CH_0 + 8'(d);
        if (d < 36) return ssgbd_pkg::C_CH_UA + 8'(d - 10);
        return ssgbd_pkg::C_CH_LA + 8'(d - 36);
    endfunction

    function automatic void reset_decoder();
        dec_phase     = ssgbd_pkg::PH_WIDTH;
        dec_width     = '0;
        dec_m         = '0;
        quot_count    = '0;
        quot_budget   = '0;
        rem_acc       = '0;
        rem_fill      = '0;
        prev_value    = '1;
        first_pending = 1'b1;
    endfunction

    function automatic void stop_string(input ssgbd_pkg::t_status st, input logic at_zero);
        decoded_q.push_back('{32'd0, 1'b0, 1'b1, st});
        dec_phase = at_zero ? ssgbd_pkg::PH_WIDTH : ssgbd_pkg::PH_SKIP;
    endfunction

    task automatic decode_char(input logic [7:0] c);
        int          d;
        int          nbits;
        logic        is_zero;
        logic        have;
        logic        b;
        logic [31:0] base;
        logic [31:0] found;
        logic [63:0] delta;
        logic [63:0] nxt;
        logic [63:0] vmax;
        is_zero = (c == 8'h00);
        have    = 1'b0;
        found   = '0;
        case (dec_phase)
            ssgbd_pkg::PH_WIDTH: begin
                if (c < ssgbd_pkg::C_CH_LA || c > ssgbd_pkg::C_CH_LZ) begin
                    stop_string(ssgbd_pkg::ST_BAD_WIDTH, is_zero);
                    return;
                end
                dec_width = 6'(c - ssgbd_pkg::C_CH_LA + 8'd7);
                dec_phase = ssgbd_pkg::PH_M;
                return;
            end
            ssgbd_pkg::PH_M: begin
                if (c < ssgbd_pkg::C_CH_UA || c > ssgbd_pkg::C_CH_UZ) begin
                    stop_string(ssgbd_pkg::ST_BAD_M, is_zero);
                    return;
                end
                dec_m = 5'(c - ssgbd_pkg::C_CH_UA + 8'd5);
                if (6'(dec_m) >= dec_width) begin
                    stop_string(ssgbd_pkg::ST_M_WIDTH, is_zero);
                    return;
                end
                quot_count    = '0;
                quot_budget   = (32'd1 << (dec_width - 6'(dec_m))) - 32'd1;
                rem_acc       = '0;
                rem_fill      = '0;
                prev_value    = '1;
                first_pending = 1'b1;
                dec_phase     = ssgbd_pkg::PH_FIRST;
                return;
            end
            ssgbd_pkg::PH_SKIP: begin
                if (is_zero) dec_phase = ssgbd_pkg::PH_WIDTH;
                return;
            end
            ssgbd_pkg::PH_BUDGET: begin
                stop_string(ssgbd_pkg::ST_BUDGET, is_zero);
                return;
            end
            ssgbd_pkg::PH_FIRST, ssgbd_pkg::PH_QUOT, ssgbd_pkg::PH_REM: begin
            end
            default: begin
                dec_phase = ssgbd_pkg::PH_WIDTH;
                return;
            end
        endcase

        if (is_zero) begin
            if (dec_phase == ssgbd_pkg::PH_FIRST) begin
                stop_string(ssgbd_pkg::ST_EMPTY, 1'b1);
            end else if (dec_phase == ssgbd_pkg::PH_REM || quot_count > 32'd5) begin
                stop_string(ssgbd_pkg::ST_INCOMPLETE, 1'b1);
            end else begin
                stop_string(ssgbd_pkg::ST_OK, 1'b1);
            end
            return;
        end

        if (c >= ssgbd_pkg::C_CH_0 && c <= ssgbd_pkg::C_CH_9)
            d = int'(c) - int'(ssgbd_pkg::C_CH_0);
        else if (c >= ssgbd_pkg::C_CH_UA && c <= ssgbd_pkg::C_CH_UZ)
            d = int'(c) - int'(ssgbd_pkg::C_CH_UA) + 10;
        else if (c >= ssgbd_pkg::C_CH_LA && c <= ssgbd_pkg::C_CH_LZ)
            d = int'(c) - int'(ssgbd_pkg::C_CH_LA) + 36;
        else d = -1;
        if (d < 0) begin
            stop_string(ssgbd_pkg::ST_BAD_CHAR, 1'b0);
            return;
        end
        if (dec_phase == ssgbd_pkg::PH_FIRST) dec_phase = ssgbd_pkg::PH_QUOT;

        nbits = (d == 30 || d == 31) ? 5 : 6;
        for (int i = 0; i < nbits; i++) begin
            b = d[i];
            if (dec_phase == ssgbd_pkg::PH_QUOT) begin
                if (!b) begin
                    if (quot_count != '1) quot_count++;
                    continue;
                end
                if (quot_count > quot_budget) begin
                    if (have) begin
                        dec_phase = ssgbd_pkg::PH_BUDGET;
                        break;
                    end
                    stop_string(ssgbd_pkg::ST_BUDGET, 1'b0);
                    return;
                end
                quot_budget -= quot_count;
                rem_acc   = '0;
                rem_fill  = '0;
                dec_phase = ssgbd_pkg::PH_REM;
            end else begin
                rem_acc  |= 32'(b) << rem_fill;
                rem_fill++;
                if (rem_fill < dec_m) continue;
                delta = (64'(quot_count) << dec_m) | 64'(rem_acc);
                base  = prev_value + 32'd1;
                if (!first_pending && base == 32'd0) begin
                    stop_string(ssgbd_pkg::ST_WRAP, 1'b0);
                    return;
                end
                nxt = 64'(base) + delta;
                if (nxt > 64'hFFFF_FFFF) begin
                    stop_string(ssgbd_pkg::ST_WRAP, 1'b0);
                    return;
                end
                vmax = (64'd1 << dec_width) - 64'd1;
                if (nxt > vmax) begin
                    stop_string(ssgbd_pkg::ST_RANGE, 1'b0);
                    return;
                end
                prev_value    = nxt[31:0];
                first_pending = 1'b0;
                quot_count    = '0;
                rem_acc       = '0;
                rem_fill      = '0;
                dec_phase     = ssgbd_pkg::PH_QUOT;
                found         = nxt[31:0];
                have          = 1'b1;
            end
        end
        if (have) decoded_q.push_back('{found, 1'b1, 1'b0, ssgbd_pkg::ST_OK});
    endtask

    // called and returns at a rising edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        bit held;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do begin
            @(negedge i_clk);
            held = o_in_stall;
            @(posedge i_clk);
        end while (held);
        decode_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit with_term);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        if (with_term) send_char(8'h00);
        strings_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (decoded_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic send_random_string();
        int wi;
        int mi;
        int mhi;
        int len;
        int d;
        wi = $urandom_range(0, 25);
        if ($urandom_range(0, 99) < 85) begin
            mhi = (wi + 1 > 25) ? 25 : wi + 1;
            if ($urandom_range(0, 1) == 0 && mhi > 4) mhi = 4;
            mi = $urandom_range(0, mhi);
            send_char(ssgbd_pkg::C_CH_LA + 8'(wi));
            send_char(ssgbd_pkg::C_CH_UA + 8'(mi));
        end else begin
            // header from random bytes, which may be broken
            send_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                           : ssgbd_pkg::C_CH_LA + 8'(wi));
            send_char(8'($urandom_range(0, 255)));
        end
        len = $urandom_range(0, 24);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_char(8'($urandom_range(0, 255)));
            end else begin
                d = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 31) : $urandom_range(0, 61);
                send_char(digit_char(d));
            end
        end
        if ($urandom_range(0, 99) < 92) send_char(8'h00);
        strings_sent++;
    endtask

    task automatic test_header_cases();
        send_char(8'h00);
        send_text("a", 1'b1);
        send_text("aC", 1'b1);
        send_text("zZ", 1'b1);
        send_text("#", 1'b1);
    endtask

    task automatic test_body_cases();
        send_text("aA1U0", 1'b1);
        send_text("aA001", 1'b1);
    endtask

    task automatic test_random_strings(input int upto);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (chars_sent < upto) send_random_string();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        stop_at = chars_sent + 200;
        while (chars_sent < stop_at) send_random_string();
    endtask

    task automatic test_backpressure();
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b1;
        send_char(8'h00);
        send_char(ssgbd_pkg::C_CH_LZ);
        send_char(ssgbd_pkg::C_CH_UA);
        for (int i = 0; i < 40; i++) send_char(ssgbd_pkg::C_CH_0 + 8'd1);
        send_char(8'h00);
    endtask

    task automatic test_drained_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (3) send_random_string();
        drain_results();
        repeat (3) send_random_string();
    endtask

    // receiver: random stalls while rx_idle is set, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
        end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // beats are judged at the falling edge, where everything is settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            in_beat  = i_in_valid && !o_in_stall;
            out_beat = o_out_valid && !i_out_stall;
            if (out_beat) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: value %h vld %b done %b status %0d",
                                 o_value, o_value_valid, o_done_res, o_status);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_value !== want.value || o_value_valid !== want.value_valid ||
                        o_done_res !== want.done_res || o_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at beat %0d: expected value %h vld %b done %b",
                                      " status %0d, got value %h vld %b done %b status %0d"},
                                     beats_checked, want.value, want.value_valid,
                                     want.done_res, want.status, o_value, o_value_valid,
                                     o_done_res, o_status);
                    end
                end
                beats_checked++;
            end
            if (in_beat || out_beat) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, decoded_q.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        reset_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_cases();
        test_body_cases();
        test_random_strings(900);
        test_steady_stream();
        test_backpressure();
        test_drained_pause();
        test_random_strings(ITEM_TARGET);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (decoded_q.size() != 0) mismatches++;

        $display("%0d characters in %0d strings sent, %0d result beats checked",
                 chars_sent, strings_sent, beats_checked);
        $display("header and body faults, terminators, random stalls, long hold, drained pause");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ssgbd_pkg.sv
rtl/sorted_set_golomb_base62_decoder_unit.sv
dv/tb_top.sv
